// ----- rtl/vax_pkg.sv -----
// Shared types and constants for the vector axis rotation block.
`default_nettype none
package vax_pkg;

  localparam int CORDIC_STEPS = 31;
  // sine/cosine datapath width (Q2.30 plus headroom)
  localparam int TRIG_W  = 34;
  // matrix entry width: c + 4*(1-c) plus a sine term
  localparam int ENTRY_W = 37;
  localparam int LIMB_W  = 17;
  localparam int PROD_W  = ENTRY_W + LIMB_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RES_W   = 64;

  localparam logic signed [TRIG_W-1:0]  CORDIC_GAIN = TRIG_W'(32'h26DD3B6A);
  localparam logic signed [ENTRY_W-1:0] Q30_ONE     = ENTRY_W'(64'h4000_0000);

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001
  };

  // angle register, CORDIC steps, sign fix
  localparam int CORD_LAT = CORDIC_STEPS + 2;
  localparam int DOT_LAT  = 4;

  typedef enum logic [1:0] {
    CMD_YAW   = 2'd0,
    CMD_PITCH = 2'd1,
    CMD_ROLL  = 2'd2,
    CMD_AXIS  = 2'd3
  } rot_cmd_e;

  typedef struct packed {
    rot_cmd_e           cmd;
    logic signed [1:0]  ax;
    logic signed [1:0]  ay;
    logic signed [1:0]  az;
  } side_t;

  typedef logic signed [ENTRY_W-1:0] entry_t;

endpackage
`default_nettype wire

// ----- rtl/vax_cordic.sv -----
// Pipelined CORDIC: one rotation step per stage, yields sine and cosine in Q30.
`default_nettype none
module vax_cordic #(
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic [ANGLE_WIDTH-1:0]                 angle_i,
  output logic signed [vax_pkg::TRIG_W-1:0]           sin_o,
  output logic signed [vax_pkg::TRIG_W-1:0]           cos_o
);

  localparam int TW = vax_pkg::TRIG_W;
  localparam int NS = vax_pkg::CORDIC_STEPS;

  logic [31:0] u, uf;
  logic        flip_d;

  logic signed [TW-1:0] x_q [NS+1];
  logic signed [TW-1:0] y_q [NS+1];
  logic signed [TW-1:0] z_q [NS+1];
  logic                 flip_q [NS+1];

  // fold [1/4, 3/4) turn onto the right half plane
  assign u      = {angle_i, {(32-ANGLE_WIDTH){1'b0}}};
  assign flip_d = u[31] ^ u[30];
  assign uf     = flip_d ? (u ^ 32'h8000_0000) : u;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= vax_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= TW'(signed'(uf));
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [TW-1:0] dx, dy, at;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign at = TW'(vax_pkg::ATAN_TURNS[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][TW-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + at;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= flip_q[NS] ? -x_q[NS] : x_q[NS];
      sin_o <= flip_q[NS] ? -y_q[NS] : y_q[NS];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vax_matrix.sv -----
// Builds the registered 3x3 rotation matrix from sine, cosine and the command.
`default_nettype none
module vax_matrix (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire vax_pkg::side_t                       side_i,
  input  wire logic signed [vax_pkg::TRIG_W-1:0]    sin_i,
  input  wire logic signed [vax_pkg::TRIG_W-1:0]    cos_i,
  output vax_pkg::entry_t                           m_o [9]
);

  vax_pkg::entry_t se, ce, cc;
  vax_pkg::entry_t ex, ey, ez;
  logic signed [3:0] pxx, pyy, pzz, pxy, pxz, pyz;
  vax_pkg::entry_t m_d [9];

  assign se  = vax_pkg::ENTRY_W'(sin_i);
  assign ce  = vax_pkg::ENTRY_W'(cos_i);
  assign cc  = vax_pkg::Q30_ONE - ce;
  assign ex  = vax_pkg::ENTRY_W'(side_i.ax);
  assign ey  = vax_pkg::ENTRY_W'(side_i.ay);
  assign ez  = vax_pkg::ENTRY_W'(side_i.az);
  assign pxx = 4'(side_i.ax) * 4'(side_i.ax);
  assign pyy = 4'(side_i.ay) * 4'(side_i.ay);
  assign pzz = 4'(side_i.az) * 4'(side_i.az);
  assign pxy = 4'(side_i.ax) * 4'(side_i.ay);
  assign pxz = 4'(side_i.ax) * 4'(side_i.az);
  assign pyz = 4'(side_i.ay) * 4'(side_i.az);

  always_comb begin
    for (int k = 0; k < 9; k++) m_d[k] = '0;
    unique case (side_i.cmd)
      vax_pkg::CMD_YAW: begin
        m_d[0] = ce;  m_d[1] = -se;
        m_d[3] = se;  m_d[4] = ce;
        m_d[8] = vax_pkg::Q30_ONE;
      end
      vax_pkg::CMD_PITCH: begin
        m_d[0] = ce;  m_d[2] = se;
        m_d[4] = vax_pkg::Q30_ONE;
        m_d[6] = -se; m_d[8] = ce;
      end
      vax_pkg::CMD_ROLL: begin
        m_d[0] = vax_pkg::Q30_ONE;
        m_d[4] = ce;  m_d[5] = -se;
        m_d[7] = se;  m_d[8] = ce;
      end
      vax_pkg::CMD_AXIS: begin
        // Rodrigues form, axis taken as given
        m_d[0] = ce + vax_pkg::ENTRY_W'(pxx) * cc;
        m_d[1] = vax_pkg::ENTRY_W'(pxy) * cc - ez * se;
        m_d[2] = vax_pkg::ENTRY_W'(pxz) * cc + ey * se;
        m_d[3] = vax_pkg::ENTRY_W'(pxy) * cc + ez * se;
        m_d[4] = ce + vax_pkg::ENTRY_W'(pyy) * cc;
        m_d[5] = vax_pkg::ENTRY_W'(pyz) * cc - ex * se;
        m_d[6] = vax_pkg::ENTRY_W'(pxz) * cc - ey * se;
        m_d[7] = vax_pkg::ENTRY_W'(pyz) * cc + ex * se;
        m_d[8] = ce + vax_pkg::ENTRY_W'(pzz) * cc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) m_o <= m_d;
  end

endmodule
`default_nettype wire

// ----- rtl/vax_dot.sv -----
// One matrix row times the vector: limb products, sums, rounding, saturation.
`default_nettype none
module vax_dot #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire vax_pkg::entry_t               m_i [3],
  input  wire logic signed [COORD_WIDTH-1:0] v_i [3],
  output logic signed [COORD_WIDTH-1:0]      r_o
);

  localparam int PW = vax_pkg::PROD_W;
  localparam int AW = vax_pkg::ACC_W;
  localparam int RW = vax_pkg::RES_W;
  localparam int LW = vax_pkg::LIMB_W;
  localparam logic signed [RW-1:0] SAT_HI = (RW'(1) <<< (COORD_WIDTH-1)) - RW'(1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
  localparam logic signed [AW-1:0] HALF   = AW'(64'h2000_0000);

  logic signed [PW-1:0] p_q [3][3];
  logic signed [AW-1:0] s0_q, s1_q, s2_q, s2b_q;
  logic signed [AW:0]   t_q;
  logic signed [RW-1:0] r_d;

  // stage 1: limb products (16-bit low and middle limbs, signed high limb)
  for (genvar k = 0; k < 3; k++) begin : g_limb
    logic signed [RW-1:0] v64;
    logic signed [LW-1:0] lo, mid, hi;
    assign v64 = RW'(v_i[k]);
    assign lo  = {1'b0, v64[15:0]};
    assign mid = {1'b0, v64[31:16]};
    assign hi  = v64[48:32];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k][0] <= PW'(m_i[k]) * PW'(lo);
        p_q[k][1] <= PW'(m_i[k]) * PW'(mid);
        p_q[k][2] <= PW'(m_i[k]) * PW'(hi);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q  <= AW'(p_q[0][0]) + AW'(p_q[1][0]) + AW'(p_q[2][0]);
      s1_q  <= AW'(p_q[0][1]) + AW'(p_q[1][1]) + AW'(p_q[2][1]);
      s2_q  <= AW'(p_q[0][2]) + AW'(p_q[1][2]) + AW'(p_q[2][2]);
      // round half up at 2^-30, carried through the limbs
      t_q   <= (AW+1)'(s1_q) + (AW+1)'((s0_q + HALF) >>> 16);
      s2b_q <= s2_q;
    end
  end

  always_comb begin
    r_d = (RW'(s2b_q) <<< 2) + RW'(t_q >>> 14);
    if (r_d > SAT_HI)      r_d = SAT_HI;
    else if (r_d < SAT_LO) r_d = SAT_LO;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_o <= COORD_WIDTH'(r_d);
  end

endmodule
`default_nettype wire

// ----- rtl/vector_axis_rotation.sv -----
// Vector axis rotation: top level with the pipeline control and delay lines.
// Rotates one Q16.16 vector per word about z, y, x or a small integer axis.
// A new word is taken every cycle while the output side keeps up; each word
// passes through the 31-stage CORDIC sine/cosine unit, the matrix build
// register and the multiply, sum and rounding stages. The whole pipeline
// holds while a finished word waits at the output. Results saturate to the
// signed coordinate range.
`default_nettype none
module vector_axis_rotation #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    cmd_i,
  input  wire logic signed [COORD_WIDTH-1:0] vec_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] vec_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] vec_z_i,
  input  wire logic [ANGLE_WIDTH-1:0]        turn_angle_i,
  input  wire logic signed [1:0]             axis_x_i,
  input  wire logic signed [1:0]             axis_y_i,
  input  wire logic signed [1:0]             axis_z_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [COORD_WIDTH-1:0]      rot_x_o,
  output logic signed [COORD_WIDTH-1:0]      rot_y_o,
  output logic signed [COORD_WIDTH-1:0]      rot_z_o
);

  localparam int CL  = vax_pkg::CORD_LAT;
  localparam int VL  = CL + 1;
  localparam int LAT = VL + vax_pkg::DOT_LAT;

  logic en;
  logic [LAT-1:0] valid_q;

  vax_pkg::side_t side_d;
  vax_pkg::side_t side_q [CL];
  logic signed [COORD_WIDTH-1:0] vec_q [VL][3];

  logic signed [vax_pkg::TRIG_W-1:0] sin_w, cos_w;
  vax_pkg::entry_t m_w [9];

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], in_valid_i};
    end
  end

  assign side_d = '{cmd: vax_pkg::rot_cmd_e'(cmd_i), ax: axis_x_i, ay: axis_y_i,
                    az: axis_z_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0]    <= side_d;
      vec_q[0][0]  <= vec_x_i;
      vec_q[0][1]  <= vec_y_i;
      vec_q[0][2]  <= vec_z_i;
      for (int i = 1; i < CL; i++) side_q[i] <= side_q[i-1];
      for (int i = 1; i < VL; i++) vec_q[i] <= vec_q[i-1];
    end
  end

  vax_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (turn_angle_i),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  vax_matrix u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .side_i (side_q[CL-1]),
    .sin_i  (sin_w),
    .cos_i  (cos_w),
    .m_o    (m_w)
  );

  vax_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_x (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   ('{m_w[0], m_w[1], m_w[2]}),
    .v_i   (vec_q[VL-1]),
    .r_o   (rot_x_o)
  );

  vax_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_y (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   ('{m_w[3], m_w[4], m_w[5]}),
    .v_i   (vec_q[VL-1]),
    .r_o   (rot_y_o)
  );

  vax_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot_z (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   ('{m_w[6], m_w[7], m_w[8]}),
    .v_i   (vec_q[VL-1]),
    .r_o   (rot_z_o)
  );

endmodule
`default_nettype wire

// ----- rtl/vax_checker.sv -----
// Port-level checks for the vector axis rotation block, bound to the top level.
`default_nettype none
module vax_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [COORD_WIDTH-1:0] rot_x_o,
  input wire logic [COORD_WIDTH-1:0] rot_y_o,
  input wire logic [COORD_WIDTH-1:0] rot_z_o
);

  // pipeline moves exactly when the output word is free or taken
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready does not track output stall");

  // a new word appears at the output only after the pipeline has advanced
  a_rose_needs_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("output word appeared while pipeline stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rot_x_o)
      && $stable(rot_y_o) && $stable(rot_z_o))
    else $error("stalled output word changed");

  a_fall_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("output word dropped without being taken");

endmodule

bind vector_axis_rotation vax_checker #(.COORD_WIDTH(COORD_WIDTH)) u_vax_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .rot_x_o     (rot_x_o),
  .rot_y_o     (rot_y_o),
  .rot_z_o     (rot_z_o)
);
`default_nettype wire

// ----- tb/vector_axis_rotation_check.sv -----
// Checker for the vector axis rotation block: predicts each rotated word and compares.
module vector_axis_rotation_check (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [31:0] vec_x_i,
  input  wire logic signed [31:0] vec_y_i,
  input  wire logic signed [31:0] vec_z_i,
  input  wire logic [15:0]        turn_angle_i,
  input  wire logic signed [1:0]  axis_x_i,
  input  wire logic signed [1:0]  axis_y_i,
  input  wire logic signed [1:0]  axis_z_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] rot_x_i,
  input  wire logic signed [31:0] rot_y_i,
  input  wire logic signed [31:0] rot_z_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  vec3_t rotated_q[$];

  initial fail_count_o = 0;
  assign pending_o = rotated_q.size();

  function automatic longint floor_div(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC sine and cosine in Q.30, with the half-turn fold
  function automatic void trig_of(input logic [15:0] ang, output longint s,
                                  output longint c);
    logic [31:0] u;
    bit flip;
    longint x, y, z, dx, dy;
    u = {ang, 16'h0};
    flip = 1'b0;
    x = 64'h26DD3B6A;
    y = 0;
    if (((u + 32'h4000_0000) & 32'h8000_0000) != 0) begin
      u = u + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(u));
    for (int i = 0; i < vax_pkg::CORDIC_STEPS; i++) begin
      dx = floor_div(y, i);
      dy = floor_div(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(vax_pkg::ATAN_TURNS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(vax_pkg::ATAN_TURNS[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [31:0] row_dot(longint m0, longint m1, longint m2,
                                                  longint v0, longint v1, longint v2);
    longint m[3], v[3];
    longint s0, s1, s2, r;
    m = '{m0, m1, m2};
    v = '{v0, v1, v2};
    s0 = 0; s1 = 0; s2 = 0;
    for (int k = 0; k < 3; k++) begin
      s0 += m[k] * (v[k] & 64'hFFFF);
      s1 += m[k] * ((v[k] >>> 16) & 64'hFFFF);
      s2 += m[k] * (v[k] >>> 32);
    end
    r = 4 * s2 + floor_div(s1 + floor_div(s0 + (64'sd1 <<< 29), 16), 14);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic vec3_t rotate_word(vax_pkg::rot_cmd_e cmd, longint vx, longint vy,
                                        longint vz, logic [15:0] ang, longint ax,
                                        longint ay, longint az);
    longint s, c, cc, q1;
    longint m[3][3];
    vec3_t res;
    q1 = 64'sd1 <<< 30;
    trig_of(ang, s, c);
    cc = q1 - c;
    m = '{default: 0};
    case (cmd)
      vax_pkg::CMD_YAW: begin
        m[0][0] = c; m[0][1] = -s; m[1][0] = s; m[1][1] = c; m[2][2] = q1;
      end
      vax_pkg::CMD_PITCH: begin
        m[0][0] = c; m[0][2] = s; m[1][1] = q1; m[2][0] = -s; m[2][2] = c;
      end
      vax_pkg::CMD_ROLL: begin
        m[0][0] = q1; m[1][1] = c; m[1][2] = -s; m[2][1] = s; m[2][2] = c;
      end
      default: begin
        m[0][0] = c + ax * ax * cc;
        m[0][1] = ax * ay * cc - az * s;
        m[0][2] = ax * az * cc + ay * s;
        m[1][0] = ay * ax * cc + az * s;
        m[1][1] = c + ay * ay * cc;
        m[1][2] = ay * az * cc - ax * s;
        m[2][0] = az * ax * cc - ay * s;
        m[2][1] = az * ay * cc + ax * s;
        m[2][2] = c + az * az * cc;
      end
    endcase
    res.x = row_dot(m[0][0], m[0][1], m[0][2], vx, vy, vz);
    res.y = row_dot(m[1][0], m[1][1], m[1][2], vx, vy, vz);
    res.z = row_dot(m[2][0], m[2][1], m[2][2], vx, vy, vz);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    vec3_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        rotated_q.push_back(rotate_word(vax_pkg::rot_cmd_e'(cmd_i), vec_x_i, vec_y_i,
                                        vec_z_i, turn_angle_i, axis_x_i, axis_y_i,
                                        axis_z_i));
      if (out_valid_i && out_ready_i) begin
        if (rotated_q.size() == 0) begin
          report_mismatch("unexpected word", rot_x_i, 'x);
        end else begin
          want = rotated_q.pop_front();
          if (rot_x_i !== want.x) report_mismatch("rot_x", rot_x_i, want.x);
          if (rot_y_i !== want.y) report_mismatch("rot_y", rot_y_i, want.y);
          if (rot_z_i !== want.z) report_mismatch("rot_z", rot_z_i, want.z);
        end
      end
    end
  end
endmodule

// ----- tb/vector_axis_rotation_test.sv -----
// Testbench top for the vector axis rotation block: stimulus, stalls and verdict.
module vector_axis_rotation_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 38;
  localparam longint CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] cmd = vax_pkg::CMD_YAW;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic [15:0] turn_angle = '0;
  logic signed [1:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] rot_x, rot_y, rot_z;
  int fail_count, pending;
  bit hold_off = 1'b0;
  longint cycles = 0;

  always #10 clk = ~clk;

  vector_axis_rotation uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .turn_angle_i(turn_angle),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .rot_x_o(rot_x), .rot_y_o(rot_y), .rot_z_o(rot_z)
  );

  vector_axis_rotation_check checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .cmd_i(cmd), .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .turn_angle_i(turn_angle),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .rot_x_i(rot_x), .rot_y_i(rot_y), .rot_z_i(rot_z),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0003_FFFF);
      3: return -$urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // ready is looked at mid-cycle, where it holds the value seen by the next edge
  task automatic send_word(logic [1:0] c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [15:0] a, logic [1:0] ax, logic [1:0] ay,
                           logic [1:0] az);
    in_valid <= 1'b1;
    cmd <= c; vec_x <= x; vec_y <= y; vec_z <= z; turn_angle <= a;
    axis_x <= ax; axis_y <= ay; axis_z <= az;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      n = (cycles % 4000 < 800) ? 0 : gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    logic [15:0] angles[8];
    int wait_cnt;
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF, 16'h2000,
               16'hBFFF};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each rotation kind over four of the angle corners, then axis and coordinate corners
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++)
        send_word(k[1:0], 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000,
                  angles[(k + 2 * j) % 8], 2'b01, 2'b11, 2'b01);
    send_word(vax_pkg::CMD_AXIS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000,
              2'b10, 2'b10, 2'b10);
    send_word(vax_pkg::CMD_AXIS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h6000,
              2'b10, 2'b01, 2'b11);
    send_word(vax_pkg::CMD_AXIS, 32'h1234_5678, 32'h8765_4321, 32'h0, 16'h1234,
              2'b00, 2'b00, 2'b00);
    send_word(vax_pkg::CMD_YAW, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h2000,
              2'b00, 2'b00, 2'b00);
    send_word(vax_pkg::CMD_ROLL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hE000,
              2'b11, 2'b11, 2'b11);

    for (int i = 0; i < 1400; i++) begin
      if (i == 400) hold_off = 1'b1;
      if (i == 900) begin
        // sender pause until the pipeline has drained
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      send_word(2'($urandom_range(0, 3)), pick_coord(), pick_coord(), pick_coord(),
                ($urandom_range(0, 7) == 0) ? angles[$urandom_range(0, 7)] :
                16'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      if (cycles % 3000 >= 600) idle_gap(gap_len());
    end
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
